// ===== hdl/ir_remote_keypad_number_entry_core_assert.svh =====
// ---------------------------------------------------------------------------
// IR keypad assertion macros
// Clocked property wrappers used by the port checker.
// ---------------------------------------------------------------------------
`ifndef IR_REMOTE_KEYPAD_NUMBER_ENTRY_CORE_ASSERT_SVH
`define IR_REMOTE_KEYPAD_NUMBER_ENTRY_CORE_ASSERT_SVH

// General property, checked on every rising edge outside reset.
`define IRKP_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("ir keypad: property failed");

// A stalled channel keeps the given signal stable.
`define IRKP_ASSERT_HOLD(lbl, clk, rstn, vld, rdy, sig) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) \
    ((vld) && !(rdy) |=> $stable(sig))) \
    else $error("ir keypad: stalled item changed");

`endif

// ===== hdl/ir_kp_pkg.sv =====
// ---------------------------------------------------------------------------
// IR keypad package
// Key codes, thresholds and widths shared by the IR keypad blocks.
// ---------------------------------------------------------------------------
package ir_kp_pkg;

  localparam int CODE_W  = 32;
  localparam int KEY_W   = 4;
  localparam int US_W    = 17;
  localparam int COUNT_W = 4;
  localparam int VALUE_W = 31;
  localparam int NUM_KEYS = 12;

  typedef logic [CODE_W-1:0] code_t;
  typedef logic [KEY_W-1:0]  key_t;

  localparam key_t KEY_DELETE  = 4'd10;
  localparam key_t KEY_ENTER   = 4'd11;
  localparam key_t KEY_UNKNOWN = 4'd12;
  localparam key_t KEY_LAST    = 4'd11;

  // gap thresholds in microseconds: 1 ms, 2 ms, 3 ms
  localparam logic [US_W-1:0] US_1MS = 17'd1000;
  localparam logic [US_W-1:0] US_2MS = 17'd2000;
  localparam logic [US_W-1:0] US_3MS = 17'd3000;

  // entry k is the frame code of key k (digits, delete, enter)
  localparam code_t KEY_CODE [NUM_KEYS] = '{
    32'(-209228065),
    32'(-1749723041),
    32'(66219167),
    32'(-1474275809),
    32'(1106806847),
    32'(-433688129),
    32'(1382254079),
    32'(-158240897),
    32'(-936618033),
    32'(1817854287),
    32'(-661170801),
    32'(891055645)
  };

endpackage

// ===== hdl/ir_kp_mac10.sv =====
// ---------------------------------------------------------------------------
// IR keypad times-ten accumulate
// Shared unit: result = acc * 10 + addend, modulo 2^32.
// ---------------------------------------------------------------------------
module ir_kp_mac10
  import ir_kp_pkg::*;
(
  input  code_t       acc,
  input  logic [3:0]  addend,
  output code_t       result
);

  // x*10 = x*8 + x*2
  assign result = (acc << 3) + (acc << 1) + CODE_W'(addend);

endmodule

// ===== hdl/ir_remote_keypad_number_entry_core.sv =====
// ---------------------------------------------------------------------------
// IR remote keypad number entry core
// Decodes pulse-distance IR frames into keys and builds a decimal number.
// ---------------------------------------------------------------------------
// Input channel: one item per falling IR edge, in_interval_us = time since
// the previous edge. Gaps under 1 ms are dropped, 1-2 ms / 2-3 ms add a
// decimal 0 / 1 to the frame code, 3 ms or more closes the frame.
// Output channel: one item per closed frame with a nonzero code: key,
// number_ready/number_value (enter only), digits_held, digit_dropped.
// Steps: a bit edge updates the frame code while idle. A frame end runs the
// classifier over the key table, one compare per cycle, then an action step,
// then for enter a store read (ST_RD) and an accumulate through the shared
// times-ten unit (ST_ACC) per stored digit, then the output load (ST_EMIT).
// in_ready is high only while the sequencer is idle.
// If the receiver stalls, the finished item waits in the output register;
// the block keeps taking edges and stalls only when the next result is due.
// Reset (synchronous, active low) clears the frame code, digit count and the
// output valid; the digit store needs no clearing.
// ---------------------------------------------------------------------------
module ir_remote_keypad_number_entry_core
  import ir_kp_pkg::*;
#(
  parameter int MAX_DIGITS = 9
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [US_W-1:0]           in_interval_us,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [KEY_W-1:0]          out_key,
  output logic                      out_number_ready,
  output logic signed [VALUE_W-1:0] out_number_value,
  output logic [COUNT_W-1:0]        out_digits_held,
  output logic                      out_digit_dropped
);

  localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CLS  = 3'd1;
  localparam logic [2:0] ST_ACT  = 3'd2;
  localparam logic [2:0] ST_RD   = 3'd3;
  localparam logic [2:0] ST_ACC  = 3'd4;
  localparam logic [2:0] ST_EMIT = 3'd5;

  logic [2:0]         state_r, state_nxt;
  code_t              frame_code_r, frame_code_nxt;
  code_t              code_r, code_nxt;
  key_t               kidx_r, kidx_nxt;
  key_t               key_r, key_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  code_t              acc_r, acc_nxt;
  logic               ready_r, ready_nxt;
  logic               dropped_r, dropped_nxt;
  logic [3:0]         rd_data_r;

  logic                      out_valid_r, out_valid_nxt;
  logic [KEY_W-1:0]          out_key_r, out_key_nxt;
  logic                      out_ready_flag_r, out_ready_flag_nxt;
  logic [VALUE_W-1:0]        out_value_r, out_value_nxt;
  logic [COUNT_W-1:0]        out_held_r, out_held_nxt;
  logic                      out_dropped_r, out_dropped_nxt;

  logic [3:0] store_mem [MAX_DIGITS];
  logic       store_we;

  code_t      mac_a, mac_y;
  logic [3:0] mac_b;

  ir_kp_mac10 u_mac10 (
    .acc    (mac_a),
    .addend (mac_b),
    .result (mac_y)
  );

  always_comb begin
    state_nxt          = state_r;
    frame_code_nxt     = frame_code_r;
    code_nxt           = code_r;
    kidx_nxt           = kidx_r;
    key_nxt            = key_r;
    count_nxt          = count_r;
    idx_nxt            = idx_r;
    acc_nxt            = acc_r;
    ready_nxt          = ready_r;
    dropped_nxt        = dropped_r;
    out_valid_nxt      = out_valid_r;
    out_key_nxt        = out_key_r;
    out_ready_flag_nxt = out_ready_flag_r;
    out_value_nxt      = out_value_r;
    out_held_nxt       = out_held_r;
    out_dropped_nxt    = out_dropped_r;
    store_we           = 1'b0;
    mac_a              = acc_r;
    mac_b              = rd_data_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        mac_a = frame_code_r;
        mac_b = (in_interval_us < US_2MS) ? 4'd0 : 4'd1;
        if (in_valid) begin
          if (in_interval_us < US_1MS) begin
            // sub-millisecond glitch: ignored
          end else if (in_interval_us < US_3MS) begin
            frame_code_nxt = mac_y;
          end else begin
            frame_code_nxt = '0;
            code_nxt       = frame_code_r;
            if (frame_code_r != '0) begin
              acc_nxt     = '0;
              ready_nxt   = 1'b0;
              dropped_nxt = 1'b0;
              kidx_nxt    = '0;
              state_nxt   = ST_CLS;
            end
          end
        end
      end
      ST_CLS: begin
        if (code_r == KEY_CODE[kidx_r]) begin
          key_nxt   = kidx_r;
          state_nxt = ST_ACT;
        end else if (kidx_r == KEY_LAST) begin
          key_nxt   = KEY_UNKNOWN;
          state_nxt = ST_ACT;
        end else begin
          kidx_nxt = kidx_r + 4'd1;
        end
      end
      ST_ACT: begin
        state_nxt = ST_EMIT;
        if (key_r < KEY_DELETE) begin
          if (count_r < COUNT_W'(MAX_DIGITS)) begin
            store_we  = 1'b1;
            count_nxt = count_r + 4'd1;
          end else begin
            dropped_nxt = 1'b1;
          end
        end else if (key_r == KEY_DELETE) begin
          if (count_r > 4'd1) begin
            count_nxt = count_r - 4'd1;
          end
        end else if (key_r == KEY_ENTER) begin
          ready_nxt = 1'b1;
          if (count_r == '0) begin
            acc_nxt = '1;
          end else begin
            idx_nxt   = '0;
            state_nxt = ST_RD;
          end
        end
      end
      ST_RD: begin
        state_nxt = ST_ACC;
      end
      ST_ACC: begin
        acc_nxt = mac_y;
        if (COUNT_W'(idx_r) + 4'd1 == count_r) begin
          count_nxt = '0;
          state_nxt = ST_EMIT;
        end else begin
          idx_nxt   = idx_r + IDX_W'(1);
          state_nxt = ST_RD;
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt      = 1'b1;
          out_key_nxt        = key_r;
          out_ready_flag_nxt = ready_r;
          out_value_nxt      = acc_r[VALUE_W-1:0];
          out_held_nxt       = count_r;
          out_dropped_nxt    = dropped_r;
          state_nxt          = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      frame_code_r <= '0;
      count_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      frame_code_r <= frame_code_nxt;
      count_r      <= count_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    code_r           <= code_nxt;
    kidx_r           <= kidx_nxt;
    key_r            <= key_nxt;
    idx_r            <= idx_nxt;
    acc_r            <= acc_nxt;
    ready_r          <= ready_nxt;
    dropped_r        <= dropped_nxt;
    out_key_r        <= out_key_nxt;
    out_ready_flag_r <= out_ready_flag_nxt;
    out_value_r      <= out_value_nxt;
    out_held_r       <= out_held_nxt;
    out_dropped_r    <= out_dropped_nxt;
  end

  // digit store: one write port, registered read
  always_ff @(posedge clk) begin
    if (store_we) begin
      store_mem[count_r[IDX_W-1:0]] <= key_r;
    end
    if (state_r == ST_RD) begin
      rd_data_r <= store_mem[idx_r];
    end
  end

  assign in_ready          = (state_r == ST_IDLE);
  assign out_valid         = out_valid_r;
  assign out_key           = out_key_r;
  assign out_number_ready  = out_ready_flag_r;
  assign out_number_value  = out_value_r;
  assign out_digits_held   = out_held_r;
  assign out_digit_dropped = out_dropped_r;

endmodule

// ===== hdl/ir_kp_checker.sv =====
// ---------------------------------------------------------------------------
// IR keypad port checker
// Watches the top-level ports and flags inconsistent result items.
// ---------------------------------------------------------------------------
`include "ir_remote_keypad_number_entry_core_assert.svh"

module ir_kp_checker
  import ir_kp_pkg::*;
#(
  parameter int MAX_DIGITS = 9
) (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [KEY_W-1:0]          out_key,
  input logic                      out_number_ready,
  input logic signed [VALUE_W-1:0] out_number_value,
  input logic [COUNT_W-1:0]        out_digits_held,
  input logic                      out_digit_dropped
);

  logic is_enter, is_digit, held_full, held_empty, value_zero;

  assign is_enter   = (out_key == KEY_ENTER);
  assign is_digit   = (out_key < KEY_DELETE);
  assign held_full  = (out_digits_held == COUNT_W'(MAX_DIGITS));
  assign held_empty = (out_digits_held == '0);
  assign value_zero = (out_number_value == '0);

  `IRKP_ASSERT_HOLD(a_out_hold, clk, rst_n, out_valid, out_ready, out_key)

  // only enter reports a number, and enter always empties the store
  `IRKP_ASSERT(a_ready_enter, clk, rst_n, out_valid && out_number_ready |-> is_enter)
  `IRKP_ASSERT(a_enter_empty, clk, rst_n, out_valid && is_enter |-> held_empty && out_number_ready)

  // a dropped digit means a digit key hit a full store
  `IRKP_ASSERT(a_drop_full, clk, rst_n, out_valid && out_digit_dropped |-> is_digit && held_full)

  // non-enter items carry a zero number
  `IRKP_ASSERT(a_value_zero, clk, rst_n, out_valid && !out_number_ready |-> value_zero)

endmodule

bind ir_remote_keypad_number_entry_core ir_kp_checker #(.MAX_DIGITS(MAX_DIGITS)) u_ir_kp_checker (.*);

// ===== bench/ir_keypad_entry_checker.sv =====
// ----------------------------------------------------------------------------
// IR keypad number entry checker
// Watches both channels of the keypad core. It decodes each accepted edge into
// the expected key result with its own frame code and digit store, and checks
// every accepted result item field by field against the oldest one due.
// ----------------------------------------------------------------------------
module ir_keypad_entry_checker
  import ir_kp_pkg::*;
#(
  parameter int MAX_DIGITS = 9
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  logic [US_W-1:0]           in_interval_us,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  logic [KEY_W-1:0]          out_key,
  input  logic                      out_number_ready,
  input  logic signed [VALUE_W-1:0] out_number_value,
  input  logic [COUNT_W-1:0]        out_digits_held,
  input  logic                      out_digit_dropped,
  output int                        n_errors,
  output int                        n_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    key_t                key;
    logic                number_ready;
    logic [VALUE_W-1:0]  number_value;
    logic [COUNT_W-1:0]  digits_held;
    logic                digit_dropped;
  } key_result_t;

  key_result_t key_results_due[$];
  code_t       frame_code;
  key_t        digit_store [MAX_DIGITS];
  int          digit_count;

  function automatic key_t lookup_key(input code_t code);
    key_t k;
    k = KEY_UNKNOWN;
    for (int i = 0; i < NUM_KEYS; i++) begin
      if (KEY_CODE[i] == code && k == KEY_UNKNOWN) k = key_t'(i);
    end
    return k;
  endfunction

  task automatic take_edge(input logic [US_W-1:0] us);
    key_result_t res;
    logic [31:0] acc;
    if (us < US_1MS) return;
    if (us < US_2MS) begin
      frame_code = frame_code * 10;
      return;
    end
    if (us < US_3MS) begin
      frame_code = frame_code * 10 + 1;
      return;
    end
    // frame end: an empty code gives nothing
    if (frame_code == '0) return;
    res.key           = lookup_key(frame_code);
    res.number_ready  = 1'b0;
    res.number_value  = '0;
    res.digit_dropped = 1'b0;
    frame_code        = '0;
    if (res.key < KEY_DELETE) begin
      if (digit_count < MAX_DIGITS) begin
        digit_store[digit_count] = res.key;
        digit_count++;
      end else begin
        res.digit_dropped = 1'b1;
      end
    end else if (res.key == KEY_DELETE) begin
      // the last digit is never removed
      if (digit_count > 1) digit_count--;
    end else if (res.key == KEY_ENTER) begin
      res.number_ready = 1'b1;
      if (digit_count == 0) begin
        res.number_value = '1;
      end else begin
        acc = '0;
        for (int i = 0; i < digit_count; i++) acc = acc * 10 + digit_store[i];
        res.number_value = acc[VALUE_W-1:0];
      end
      digit_count = 0;
    end
    res.digits_held = COUNT_W'(digit_count);
    key_results_due.push_back(res);
  endtask

  task automatic check_result();
    key_result_t want;
    if (key_results_due.size() == 0) begin
      n_errors++;
      $error("result item with nothing due: key %0d", out_key);
      return;
    end
    want = key_results_due.pop_front();
    if (out_key !== want.key) begin
      n_errors++;
      $error("key: expected %0d, got %0d", want.key, out_key);
    end
    if (out_number_ready !== want.number_ready) begin
      n_errors++;
      $error("number_ready: expected %0d, got %0d", want.number_ready, out_number_ready);
    end
    if (out_number_value !== want.number_value) begin
      n_errors++;
      $error("number_value: expected %0d, got %0d", $signed(want.number_value),
             out_number_value);
    end
    if (out_digits_held !== want.digits_held) begin
      n_errors++;
      $error("digits_held: expected %0d, got %0d", want.digits_held, out_digits_held);
    end
    if (out_digit_dropped !== want.digit_dropped) begin
      n_errors++;
      $error("digit_dropped: expected %0d, got %0d", want.digit_dropped, out_digit_dropped);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      frame_code  = '0;
      digit_count = 0;
      n_errors    = 0;
      key_results_due.delete();
    end else begin
      // results first: an edge accepted now cannot have its result out yet
      if (out_valid && out_ready) check_result();
      if (in_valid && in_ready) take_edge(in_interval_us);
    end
    n_pending = key_results_due.size();
  end

endmodule

// ===== bench/tb_ir_remote_keypad_number_entry_core.sv =====
// ----------------------------------------------------------------------------
// IR remote keypad number entry core testbench
// Sends IR edge intervals that spell out key frames (digits, delete, enter),
// plus unknown, cut-short, empty and wrapped frames and sub-millisecond noise,
// with random gaps and receiver stalls and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_ir_remote_keypad_number_entry_core;
  import ir_kp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_DIGITS     = 9;
  localparam int MAX_US         = 99999;
  localparam int EDGE_COUNT     = 1300;
  localparam int HOLD_AT        = 400;
  localparam int HOLD_CYCLES    = 400;
  localparam int DRAIN_CYCLES   = 100;
  localparam int WATCHDOG_LIMIT = 3000;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic [US_W-1:0]           in_interval_us = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic [KEY_W-1:0]          out_key;
  logic                      out_number_ready;
  logic signed [VALUE_W-1:0] out_number_value;
  logic [COUNT_W-1:0]        out_digits_held;
  logic                      out_digit_dropped;

  int n_errors;
  int n_pending;
  int n_counted = 0;
  int idle_cycles = 0;
  bit no_gaps = 1'b0;
  bit held_off = 1'b0;

  ir_remote_keypad_number_entry_core #(.MAX_DIGITS(MAX_DIGITS)) dut (.*);

  ir_keypad_entry_checker #(.MAX_DIGITS(MAX_DIGITS)) checker_i (
    .clk, .rst_n, .in_valid, .in_ready, .in_interval_us,
    .out_valid, .out_ready, .out_key, .out_number_ready, .out_number_value,
    .out_digits_held, .out_digit_dropped, .n_errors, .n_pending
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // bit j of the result is the 0/1 digit for 10^j; 10^j mod 2^32 has bit j as
  // its lowest set bit, so the digits fall out from the bottom up
  function automatic code_t frame_bits(input code_t target);
    code_t resid, pw, mask;
    resid = target;
    pw    = 1;
    mask  = '0;
    for (int j = 0; j < CODE_W; j++) begin
      if (resid[j]) begin
        mask[j] = 1'b1;
        resid   = resid - pw;
      end
      pw = pw * 10;
    end
    return mask;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (no_gaps || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [US_W-1:0] pick_frame_end();
    if ($urandom_range(2) == 0) return US_W'($urandom_range(US_3MS, US_3MS + 999));
    return US_W'($urandom_range(US_3MS, MAX_US));
  endfunction

  task automatic send_edge(input logic [US_W-1:0] us);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_interval_us <= us;
    do @(posedge clk); while (!in_ready);
    if (us >= US_1MS) n_counted++;
  endtask

  task automatic send_bit(input bit b);
    int r;
    r = $urandom_range(7);
    if ($urandom_range(19) == 0) send_edge(US_W'($urandom_range(US_1MS - 1)));
    if (b) begin
      if (r == 0) send_edge(US_2MS);
      else if (r == 1) send_edge(US_3MS - 1);
      else send_edge(US_W'($urandom_range(US_2MS, US_3MS - 1)));
    end else begin
      if (r == 0) send_edge(US_1MS);
      else if (r == 1) send_edge(US_2MS - 1);
      else send_edge(US_W'($urandom_range(US_1MS, US_2MS - 1)));
    end
  endtask

  // prefix > 0 shifts random bits in first; they wrap out of the 32-bit code
  // once all 32 code bits follow. cut > 0 drops the lowest bits of the code.
  task automatic send_frame(input code_t code, input int prefix, input int cut,
                            input logic [US_W-1:0] end_us);
    code_t mask;
    int top;
    mask = frame_bits(code);
    top  = -1;
    for (int j = 0; j < CODE_W; j++) begin
      if (mask[j]) top = j;
    end
    if (prefix > 0) top = CODE_W - 1;
    repeat (prefix) send_bit($urandom_range(1));
    for (int j = top; j >= cut; j--) send_bit(mask[j]);
    send_edge(end_us);
  endtask

  task automatic send_key(input int k, input int prefix);
    send_frame(KEY_CODE[k], prefix, 0, pick_frame_end());
  endtask

  initial begin
    int r;
    int prefix;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed: noise, empty frame, empty enter/delete, full store, delete
    // rules, unknown code, wrapped code
    send_edge('0);
    send_edge(US_1MS - 1);
    send_edge(US_3MS);
    send_key(KEY_ENTER, 0);
    send_key(KEY_DELETE, 0);
    repeat (MAX_DIGITS) send_key(9, 0);
    send_key(0, 0);
    send_key(KEY_ENTER, 0);
    send_key(1, 0);
    send_key(2, 0);
    send_key(3, 0);
    send_key(KEY_DELETE, 0);
    send_key(KEY_ENTER, 0);
    send_key(5, 0);
    send_key(KEY_DELETE, 0);
    send_key(KEY_ENTER, 0);
    send_frame(code_t'($urandom()), 0, 0, US_W'(MAX_US));
    repeat (3) send_bit(1'b0);
    send_edge(US_W'(MAX_US));
    send_frame(KEY_CODE[7], 12, 0, US_3MS);
    send_key(KEY_ENTER, 0);

    while (n_counted < EDGE_COUNT) begin
      no_gaps = ($urandom_range(3) == 0);
      prefix  = ($urandom_range(7) == 0) ? $urandom_range(1, 12) : 0;
      r       = $urandom_range(99);
      if (r < 62) send_key($urandom_range(9), prefix);
      else if (r < 72) send_key(KEY_DELETE, prefix);
      else if (r < 86) send_key(KEY_ENTER, prefix);
      else if (r < 92) send_frame(code_t'($urandom()), prefix, 0, pick_frame_end());
      else if (r < 96) begin
        send_frame(KEY_CODE[$urandom_range(NUM_KEYS - 1)], 0, $urandom_range(1, 6),
                   pick_frame_end());
      end else begin
        repeat ($urandom_range(4)) send_bit(1'b0);
        send_edge(pick_frame_end());
      end
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (n_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (n_errors == 0 && n_pending == 0) begin
      $display("ir_remote_keypad_number_entry_core test passed");
    end else begin
      $display("ir_remote_keypad_number_entry_core test failed");
    end
    $finish;
  end

  // receiver: random stalls in phases, some phases calm, one long hold-off
  initial begin
    int stall_left;
    int phase_left;
    bit calm;
    stall_left = 0;
    phase_left = 0;
    calm       = 1'b0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (!held_off && n_counted >= HOLD_AT) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        held_off = 1'b1;
      end else begin
        if (phase_left == 0) begin
          calm       = ($urandom_range(3) == 0);
          phase_left = $urandom_range(20, 80);
        end
        phase_left--;
        if (stall_left > 0) begin
          stall_left--;
          out_ready <= 1'b0;
        end else if (!calm && $urandom_range(99) < 30) begin
          stall_left = ($urandom_range(9) < 8) ? $urandom_range(0, 2)
                                               : $urandom_range(10, 60);
          out_ready <= 1'b0;
        end else begin
          out_ready <= 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("ir_remote_keypad_number_entry_core test failed");
      $finish;
    end
  end

endmodule

// ===== ir_remote_keypad_number_entry_core.f =====
+incdir+hdl
hdl/ir_kp_pkg.sv
hdl/ir_kp_mac10.sv
hdl/ir_remote_keypad_number_entry_core.sv
hdl/ir_kp_checker.sv
bench/ir_keypad_entry_checker.sv
bench/tb_ir_remote_keypad_number_entry_core.sv
